// ===== rtl/stl_pkg.sv =====
package stl_pkg;

  localparam int TOKEN_MAX = 32;
  localparam int IDX_W = $clog2(TOKEN_MAX);
  localparam int LEN_W = $clog2(TOKEN_MAX + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  // byte classes
  localparam logic [2:0] CLS_SPACE  = 3'd0;
  localparam logic [2:0] CLS_NUMBER = 3'd1;
  localparam logic [2:0] CLS_LETTER = 3'd2;
  localparam logic [2:0] CLS_QUOTE  = 3'd3;
  localparam logic [2:0] CLS_SYMBOL = 3'd4;

  // token types
  localparam logic [4:0] TYPE_NUMBER  = 5'd0;
  localparam logic [4:0] TYPE_IDENT   = 5'd1;
  localparam logic [4:0] TYPE_STRING  = 5'd2;
  localparam logic [4:0] TYPE_HASH    = 5'd3;  // first of the punctuation types
  localparam logic [4:0] TYPE_KW0     = 5'd15;
  localparam logic [4:0] TYPE_UNKNOWN = 5'd19;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  function automatic logic [2:0] byte_class(input logic [7:0] b);
    logic [2:0] c;
    if (b == CH_QUOTE) c = CLS_QUOTE;
    else if ((b >= 8'h30 && b <= 8'h39) || b == 8'h2d || b == 8'h2e) c = CLS_NUMBER;
    else if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) || b == 8'h5f)
      c = CLS_LETTER;
    else if (b >= 8'h21 && b <= 8'h7e) c = CLS_SYMBOL;
    else c = CLS_SPACE;
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic [4:0] sym_type(input logic [7:0] b);
    logic [4:0] t;
    case (b)
      8'h23:   t = TYPE_HASH;
      8'h3a:   t = TYPE_HASH + 5'd1;
      8'h3b:   t = TYPE_HASH + 5'd2;
      8'h3d:   t = TYPE_HASH + 5'd3;
      8'h2e:   t = TYPE_HASH + 5'd4;
      8'h7b:   t = TYPE_HASH + 5'd5;
      8'h7d:   t = TYPE_HASH + 5'd6;
      8'h28:   t = TYPE_HASH + 5'd7;
      8'h29:   t = TYPE_HASH + 5'd8;
      8'h5b:   t = TYPE_HASH + 5'd9;
      8'h5d:   t = TYPE_HASH + 5'd10;
      8'h2c:   t = TYPE_HASH + 5'd11;
      default: t = TYPE_UNKNOWN;
    endcase
    return t;
  endfunction

  // keywords: define, include, setdir, undef
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd6;
      2'd1:    n = 3'd7;
      2'd2:    n = 3'd6;
      default: n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [47:0] d;
    logic [55:0] s;
    logic [7:0]  ch;
    d = 48'h0;
    s = 56'h0;
    case (k)
      2'd0:    d = "define";
      2'd1:    s = "include";
      2'd2:    d = "setdir";
      default: d = {8'h00, "undef"};
    endcase
    case (k)
      2'd1: begin
        case (p)
          3'd0:    ch = s[55:48];
          3'd1:    ch = s[47:40];
          3'd2:    ch = s[39:32];
          3'd3:    ch = s[31:24];
          3'd4:    ch = s[23:16];
          3'd5:    ch = s[15:8];
          default: ch = s[7:0];
        endcase
      end
      2'd3: begin
        case (p)
          3'd0:    ch = d[39:32];
          3'd1:    ch = d[31:24];
          3'd2:    ch = d[23:16];
          3'd3:    ch = d[15:8];
          default: ch = d[7:0];
        endcase
      end
      default: begin
        case (p)
          3'd0:    ch = d[47:40];
          3'd1:    ch = d[39:32];
          3'd2:    ch = d[31:24];
          3'd3:    ch = d[23:16];
          3'd4:    ch = d[15:8];
          default: ch = d[7:0];
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/stl_store.sv =====
module stl_store (
  input  logic            clk,
  input  logic            we,
  input  stl_pkg::idx_t   waddr,
  input  logic [7:0]      wdata,
  input  logic            re,
  input  stl_pkg::idx_t   raddr,
  output logic [7:0]      rdata
);
  import stl_pkg::*;

  logic [7:0] mem [TOKEN_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/script_token_lexer.sv =====
// channel  direction  handshake                 payload
// byte     in         byte_valid / byte_stall   byte_value, final_byte
// token    out        tok_valid / tok_stall     token_kind .. truncated, one item per char
//
// a byte inside a run, string or comment goes through the main, fin and end states;
// a byte scanned from idle or rescanned after ending a run also passes the rescan state
// each token character sent goes through a store read, then an output load
// synchronous reset returns the scanner to idle at line 1, column 1
// byte_stall is high in reset and from acceptance until the byte is fully handled;
// a stalled token item holds and the replay waits for it
module script_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_value,
  input  logic        final_byte,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [4:0]  token_kind,
  output logic [7:0]  token_char,
  output logic [4:0]  char_index,
  output logic        last_of_token,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic        truncated
);
  import stl_pkg::*;

  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_NUMBER     = 3'd1;
  localparam logic [2:0] MODE_IDENT      = 3'd2;
  localparam logic [2:0] MODE_STRING     = 3'd3;
  localparam logic [2:0] MODE_SLASH      = 3'd4;
  localparam logic [2:0] MODE_LINE_CMT   = 3'd5;
  localparam logic [2:0] MODE_BLOCK_CMT  = 3'd6;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd7;

  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_MAIN   = 3'd1;
  localparam logic [2:0] ST_RESCAN = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_END    = 3'd4;
  localparam logic [2:0] ST_EM_RD  = 3'd5;
  localparam logic [2:0] ST_EM_LD  = 3'd6;

  logic [2:0]  state, state_next;
  logic [2:0]  ret, ret_next;
  logic [2:0]  mode, mode_next;
  len_t        len, len_next;
  logic [3:0]  hits, hits_next;
  logic        cut, cut_next;
  logic [15:0] line, line_next;
  logic [15:0] col, col_next;
  logic [15:0] bline, bline_next;
  logic [15:0] bcol, bcol_next;
  idx_t        idx, idx_next;
  logic [4:0]  etype, etype_next;
  logic [7:0]  byte_r;
  logic        fin_r;

  logic        do_clear, do_store, do_mark, do_emit;
  logic [7:0]  st_char;
  logic [4:0]  emit_type;
  logic [2:0]  emit_ret;
  len_t        base_len;
  logic [3:0]  base_hits;
  logic        base_cut;
  logic [4:0]  id_type;
  logic [2:0]  cls;

  logic        mem_we;
  idx_t        mem_waddr;
  logic        mem_re;
  logic [7:0]  mem_q;

  len_t        cnt;
  logic        out_free;
  logic        em_last;

  assign byte_stall = rst || (state != ST_WAIT);
  assign cls = byte_class(byte_r);
  assign out_free = !tok_valid || !tok_stall;
  assign cnt = (len == '0) ? len_t'(1) : len;
  assign em_last = (len_t'(idx) == cnt - len_t'(1));
  assign mem_re = (state == ST_EM_RD);

  // identifier type: keyword only if its hit bit survived and the length matches
  always_comb begin
    id_type = TYPE_IDENT;
    if (!cut) begin
      for (int k = 3; k >= 0; k--) begin
        if (hits[k] && len == len_t'(kw_len(2'(k)))) begin
          id_type = TYPE_KW0 + 5'(k);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    mode_next  = mode;
    line_next  = line;
    col_next   = col;
    bline_next = bline;
    bcol_next  = bcol;
    idx_next   = idx;
    etype_next = etype;
    do_clear   = 1'b0;
    do_store   = 1'b0;
    do_mark    = 1'b0;
    do_emit    = 1'b0;
    st_char    = byte_r;
    emit_type  = TYPE_UNKNOWN;
    emit_ret   = ST_FIN;

    case (state)
      ST_WAIT: begin
        if (byte_valid) begin
          state_next = ST_MAIN;
        end
      end
      ST_MAIN: begin
        state_next = ST_FIN;
        case (mode)
          MODE_NUMBER: begin
            if (cls == CLS_NUMBER) begin
              do_store = 1'b1;
            end else begin
              do_emit = 1'b1; emit_type = TYPE_NUMBER; emit_ret = ST_RESCAN;
            end
          end
          MODE_IDENT: begin
            if (cls == CLS_LETTER) begin
              do_store = 1'b1;
            end else begin
              do_emit = 1'b1; emit_type = id_type; emit_ret = ST_RESCAN;
            end
          end
          MODE_STRING: begin
            if (byte_r == CH_QUOTE) begin
              do_emit = 1'b1; emit_type = TYPE_STRING; emit_ret = ST_FIN;
              mode_next = MODE_IDLE;
            end else begin
              do_store = 1'b1;
              st_char = (byte_r == CH_DEL) ? 8'h00 : byte_r;
            end
          end
          MODE_SLASH: begin
            if (byte_r == CH_SLASH) begin
              mode_next = MODE_LINE_CMT;
            end else if (byte_r == CH_STAR) begin
              mode_next = MODE_BLOCK_CMT;
            end else begin
              // lone slash goes out as an unknown symbol, then rescan
              do_clear = 1'b1; do_store = 1'b1; st_char = CH_SLASH;
              do_emit = 1'b1; emit_type = TYPE_UNKNOWN; emit_ret = ST_RESCAN;
            end
          end
          MODE_LINE_CMT: begin
            if (byte_r == CH_NEWLINE) mode_next = MODE_IDLE;
          end
          MODE_BLOCK_CMT: begin
            if (byte_r == CH_STAR) mode_next = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (byte_r == CH_SLASH) mode_next = MODE_IDLE;
            else if (byte_r != CH_STAR) mode_next = MODE_BLOCK_CMT;
          end
          default: begin
            state_next = ST_RESCAN;
          end
        endcase
      end
      ST_RESCAN: begin
        state_next = ST_FIN;
        mode_next = MODE_IDLE;
        case (cls)
          CLS_QUOTE: begin
            do_clear = 1'b1; do_mark = 1'b1; mode_next = MODE_STRING;
          end
          CLS_NUMBER: begin
            do_clear = 1'b1; do_mark = 1'b1; do_store = 1'b1; mode_next = MODE_NUMBER;
          end
          CLS_LETTER: begin
            do_clear = 1'b1; do_mark = 1'b1; do_store = 1'b1; mode_next = MODE_IDENT;
          end
          CLS_SYMBOL: begin
            do_mark = 1'b1;
            if (byte_r == CH_SLASH) begin
              mode_next = MODE_SLASH;
            end else begin
              do_clear = 1'b1; do_store = 1'b1;
              do_emit = 1'b1; emit_type = sym_type(byte_r); emit_ret = ST_FIN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_FIN: begin
        state_next = ST_END;
        if (fin_r) begin
          case (mode)
            MODE_NUMBER: begin
              do_emit = 1'b1; emit_type = TYPE_NUMBER; emit_ret = ST_END;
            end
            MODE_IDENT: begin
              do_emit = 1'b1; emit_type = id_type; emit_ret = ST_END;
            end
            MODE_STRING: begin
              do_emit = 1'b1; emit_type = TYPE_STRING; emit_ret = ST_END;
            end
            MODE_SLASH: begin
              do_clear = 1'b1; do_store = 1'b1; st_char = CH_SLASH;
              do_emit = 1'b1; emit_type = TYPE_UNKNOWN; emit_ret = ST_END;
            end
            default: begin
            end
          endcase
        end
      end
      ST_END: begin
        state_next = ST_WAIT;
        if (fin_r) begin
          mode_next = MODE_IDLE;
          do_clear = 1'b1;
          line_next = 16'd1;
          col_next = 16'd1;
        end else if (byte_r == CH_NEWLINE) begin
          if (line != 16'hffff) line_next = line + 16'd1;
          col_next = 16'd1;
        end else begin
          if (col != 16'hffff) col_next = col + 16'd1;
        end
      end
      ST_EM_RD: begin
        state_next = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (out_free) begin
          if (em_last) begin
            state_next = ret;
          end else begin
            idx_next = idx + idx_t'(1);
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase

    if (do_mark) begin
      bline_next = line;
      bcol_next = col;
    end
    if (do_emit) begin
      etype_next = emit_type;
      ret_next = emit_ret;
      idx_next = '0;
      state_next = ST_EM_RD;
    end

    // token store append with keyword tracking
    base_len  = do_clear ? '0 : len;
    base_hits = do_clear ? 4'hf : hits;
    base_cut  = do_clear ? 1'b0 : cut;
    len_next  = base_len;
    hits_next = base_hits;
    cut_next  = base_cut;
    mem_we    = 1'b0;
    mem_waddr = idx_t'(base_len);
    if (do_store) begin
      if (base_len >= len_t'(TOKEN_MAX)) begin
        cut_next = 1'b1;
        hits_next = 4'h0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (base_hits[k] && (base_len >= len_t'(kw_len(2'(k))) ||
              to_lower(st_char) != kw_char(2'(k), 3'(base_len)))) begin
            hits_next[k] = 1'b0;
          end
        end
        mem_we = 1'b1;
        len_next = base_len + len_t'(1);
      end
    end
  end

  stl_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (st_char),
    .re    (mem_re),
    .raddr (idx),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
      ret   <= ST_FIN;
      mode  <= MODE_IDLE;
      len   <= '0;
      hits  <= 4'hf;
      cut   <= 1'b0;
      line  <= 16'd1;
      col   <= 16'd1;
      bline <= 16'd1;
      bcol  <= 16'd1;
      idx   <= '0;
      etype <= TYPE_NUMBER;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      mode  <= mode_next;
      len   <= len_next;
      hits  <= hits_next;
      cut   <= cut_next;
      line  <= line_next;
      col   <= col_next;
      bline <= bline_next;
      bcol  <= bcol_next;
      idx   <= idx_next;
      etype <= etype_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && byte_valid) begin
      byte_r <= byte_value;
      fin_r  <= final_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (state == ST_EM_LD && out_free) begin
      tok_valid <= 1'b1;
    end else if (!tok_stall) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EM_LD && out_free) begin
      token_kind    <= etype;
      token_char    <= (len_t'(idx) < len) ? mem_q : 8'h00;
      char_index    <= 5'(idx);
      last_of_token <= em_last;
      start_line    <= bline;
      start_column  <= bcol;
      truncated     <= cut;
    end
  end

  a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall) |=> byte_stall)
    else $error("byte accepted while previous byte still in work");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && !tok_stall && !last_of_token) |=> byte_stall)
    else $error("input opened in the middle of a token run");

  a_cut_not_keyword: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && truncated) |->
      (token_kind != TYPE_KW0 && token_kind != TYPE_KW0 + 5'd1 &&
       token_kind != TYPE_KW0 + 5'd2 && token_kind != TYPE_KW0 + 5'd3))
    else $error("truncated token marked as keyword");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    (len > len_t'(TOKEN_MAX)) |-> 1'b0)
    else $error("token length beyond store");

endmodule

// ===== test/tb_script_token_lexer.sv =====
module tb_script_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 135;

  typedef enum logic [2:0] {
    LX_IDLE, LX_NUMBER, LX_WORD, LX_STRING, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR
  } lex_mode_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

  typedef struct packed {
    logic [4:0]  ttype;
    logic [7:0]  ch;
    logic [4:0]  idx;
    logic        last;
    logic [15:0] line;
    logic [15:0] col;
    logic        cut;
  } tok_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    chk_t       chk;
    tok_t       tok;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  byte_value = 8'h00;
  logic        final_byte = 1'b0;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [7:0]  token_char;
  logic [4:0]  char_index;
  logic        last_of_token;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        truncated;

  script_token_lexer DUT (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_value    (byte_value),
    .final_byte    (final_byte),
    .tok_valid     (tok_valid),
    .tok_stall     (tok_stall),
    .token_kind    (token_kind),
    .token_char    (token_char),
    .char_index    (char_index),
    .last_of_token (last_of_token),
    .start_line    (start_line),
    .start_column  (start_column),
    .truncated     (truncated)
  );

  // scanner copy
  lex_mode_t   lex_mode;
  logic [7:0]  tok_buf [TOKEN_MAX];
  int          tok_len;
  logic [3:0]  kw_live;
  logic [15:0] cur_line, cur_col, tok_line, tok_col;
  logic        tok_cut;
  string       kw_word [4];
  string       punct = "#:;=.{}()[],";
  string       odd_syms = "!$%&'*+<>?@\\^`|~/";
  string       letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  string       num_chars = "0123456789-.";
  string       cmt_chars = "ab */\n*";

  tok_t        scan_out [$];
  tok_t        pending_tokens [$];
  int          err_count = 0;
  int          rand_count = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet_cycles = 0;
  dir_row_t    dir_rows [27];
  tok_t        got_tok, want_tok;
  string       bad_fields;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] char_class(input logic [7:0] b);
    if (b == CH_QUOTE) return CLS_QUOTE;
    if ((b >= "0" && b <= "9") || b == "-" || b == ".") return CLS_NUMBER;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_") return CLS_LETTER;
    if (b >= "!" && b <= "~") return CLS_SYMBOL;
    return CLS_SPACE;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [4:0] word_type();
    int k;
    if (tok_cut) return TYPE_IDENT;
    for (k = 0; k < 4; k++)
      if (kw_live[k] && tok_len == kw_word[k].len()) return TYPE_KW0 + 5'(k);
    return TYPE_IDENT;
  endfunction

  function automatic string fmt_tok(input tok_t t);
    return $sformatf("type %0d char %h idx %0d last %b line %0d col %0d cut %b",
                     t.ttype, t.ch, t.idx, t.last, t.line, t.col, t.cut);
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic clear_token();
    tok_len = 0;
    tok_cut = 1'b0;
    kw_live = 4'hf;
  endtask

  task automatic mark_start();
    tok_line = cur_line;
    tok_col = cur_col;
  endtask

  task automatic keep_char(input logic [7:0] b);
    int k;
    if (tok_len >= TOKEN_MAX) begin
      tok_cut = 1'b1;
      kw_live = 4'h0;
    end else begin
      for (k = 0; k < 4; k++)
        if (kw_live[k] && (tok_len >= kw_word[k].len() || fold_case(b) != kw_word[k][tok_len]))
          kw_live[k] = 1'b0;
      tok_buf[tok_len] = b;
      tok_len++;
    end
  endtask

  task automatic push_token(input logic [4:0] t);
    int   cnt;
    int   i;
    tok_t r;
    cnt = (tok_len != 0) ? tok_len : 1;
    for (i = 0; i < cnt; i++) begin
      r.ttype = t;
      r.ch = (i < tok_len) ? tok_buf[i] : 8'h00;
      r.idx = i[4:0];
      r.last = (i + 1 == cnt);
      r.line = tok_line;
      r.col = tok_col;
      r.cut = tok_cut;
      scan_out.push_back(r);
    end
  endtask

  task automatic slash_token();
    clear_token();
    keep_char(CH_SLASH);
    push_token(TYPE_UNKNOWN);
  endtask

  // byte seen from idle, or re-scanned after it ended a run
  task automatic scan_fresh(input logic [7:0] b);
    int         k;
    logic [4:0] t;
    lex_mode = LX_IDLE;
    case (char_class(b))
      CLS_QUOTE: begin
        clear_token();
        mark_start();
        lex_mode = LX_STRING;
      end
      CLS_NUMBER: begin
        clear_token();
        mark_start();
        keep_char(b);
        lex_mode = LX_NUMBER;
      end
      CLS_LETTER: begin
        clear_token();
        mark_start();
        keep_char(b);
        lex_mode = LX_WORD;
      end
      CLS_SYMBOL: begin
        mark_start();
        if (b == CH_SLASH) begin
          lex_mode = LX_SLASH;
        end else begin
          t = TYPE_UNKNOWN;
          for (k = 0; k < punct.len(); k++)
            if (b == punct[k]) t = TYPE_HASH + 5'(k);
          clear_token();
          keep_char(b);
          push_token(t);
        end
      end
      default: ;
    endcase
  endtask

  task automatic lex_reset();
    lex_mode = LX_IDLE;
    clear_token();
    cur_line = 16'd1;
    cur_col = 16'd1;
    tok_line = 16'd1;
    tok_col = 16'd1;
  endtask

  // tokens caused by one byte land in scan_out
  task automatic lex_byte(input logic [7:0] b, input logic fin);
    scan_out.delete();
    case (lex_mode)
      LX_NUMBER:
        if (char_class(b) == CLS_NUMBER) keep_char(b);
        else begin
          push_token(TYPE_NUMBER);
          scan_fresh(b);
        end
      LX_WORD:
        if (char_class(b) == CLS_LETTER) keep_char(b);
        else begin
          push_token(word_type());
          scan_fresh(b);
        end
      LX_STRING:
        if (b == CH_QUOTE) begin
          push_token(TYPE_STRING);
          lex_mode = LX_IDLE;
        end else keep_char((b == CH_DEL) ? 8'h00 : b);
      LX_SLASH:
        if (b == CH_SLASH) lex_mode = LX_LINE_CMT;
        else if (b == CH_STAR) lex_mode = LX_BLOCK_CMT;
        else begin
          slash_token();
          scan_fresh(b);
        end
      LX_LINE_CMT:
        if (b == CH_NEWLINE) lex_mode = LX_IDLE;
      LX_BLOCK_CMT:
        if (b == CH_STAR) lex_mode = LX_BLOCK_STAR;
      LX_BLOCK_STAR:
        if (b == CH_SLASH) lex_mode = LX_IDLE;
        else if (b != CH_STAR) lex_mode = LX_BLOCK_CMT;
      default:
        scan_fresh(b);
    endcase
    if (fin) begin
      case (lex_mode)
        LX_NUMBER: push_token(TYPE_NUMBER);
        LX_WORD:   push_token(word_type());
        LX_STRING: push_token(TYPE_STRING);
        LX_SLASH:  slash_token();
        default: ;
      endcase
      lex_mode = LX_IDLE;
      clear_token();
      cur_line = 16'd1;
      cur_col = 16'd1;
    end else if (b == CH_NEWLINE) begin
      if (cur_line != 16'hffff) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != 16'hffff) begin
      cur_col++;
    end
  endtask

  task automatic drive_item(input logic [7:0] b, input logic fin, input chk_t chk,
                            input tok_t tok);
    int i;
    if ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_value <= b;
    final_byte <= fin;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    lex_byte(b, fin);
    case (chk)
      CHK_MODEL: for (i = 0; i < scan_out.size(); i++) pending_tokens.push_back(scan_out[i]);
      CHK_TYPED: pending_tokens.push_back(tok);
      default: ;
    endcase
  endtask

  task automatic send_char(input logic [7:0] b, input bit counted);
    drive_item(b, ($urandom_range(99) < 3), CHK_MODEL, '0);
    if (counted) rand_count++;
  endtask

  function automatic int run_len();
    return ($urandom_range(15) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
  endfunction

  // mostly well-formed tokens with random content, some noise
  task automatic random_chunk();
    int         n;
    int         i;
    string      w;
    logic [7:0] b;
    case ($urandom_range(15))
      0, 1: begin
        w = kw_word[$urandom_range(3)];
        for (i = 0; i < w.len(); i++) begin
          b = w[i];
          send_char($urandom_range(1) ? b - 8'd32 : b, 1);
        end
        if ($urandom_range(3) == 0) send_char(letters[$urandom_range(letters.len() - 1)], 1);
      end
      2, 3: begin
        n = run_len();
        repeat (n) send_char(letters[$urandom_range(letters.len() - 1)], 1);
      end
      4, 5: begin
        n = run_len();
        repeat (n) send_char(num_chars[$urandom_range(num_chars.len() - 1)], 1);
      end
      6: begin
        n = ($urandom_range(15) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 6);
        send_char(CH_QUOTE, 1);
        repeat (n) begin
          b = ($urandom_range(7) == 0) ? CH_NEWLINE : 8'($urandom_range(255));
          send_char((b == CH_QUOTE) ? CH_DEL : b, 1);
        end
        // unterminated now and then
        if ($urandom_range(7) != 0) send_char(CH_QUOTE, 1);
      end
      7, 8: send_char(punct[$urandom_range(punct.len() - 1)], 1);
      9: send_char(odd_syms[$urandom_range(odd_syms.len() - 1)], 1);
      10: begin
        send_char(CH_SLASH, 1);
        send_char(CH_SLASH, 1);
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(255));
          send_char((b == CH_NEWLINE) ? "x" : b, 1);
        end
        send_char(CH_NEWLINE, 1);
      end
      11: begin
        send_char(CH_SLASH, 1);
        send_char(CH_STAR, 1);
        repeat ($urandom_range(0, 6)) send_char(cmt_chars[$urandom_range(cmt_chars.len() - 1)], 1);
        repeat ($urandom_range(1, 3)) send_char(CH_STAR, 1);
        send_char(CH_SLASH, 1);
      end
      12, 13: begin
        case ($urandom_range(6))
          0: b = " ";
          1: b = 8'h09;
          2: b = CH_NEWLINE;
          3: b = CH_DEL;
          4: b = 8'h00;
          5: b = 8'($urandom_range(128, 255));
          default: b = 8'($urandom_range(1, 31));
        endcase
        send_char(b, 0);
      end
      default: send_char(8'($urandom_range(255)), 1);
    endcase
  endtask

  always @(posedge clk) tok_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    if (!rst && tok_valid && !tok_stall) begin
      got_tok = '{token_kind, token_char, char_index, last_of_token,
                  start_line, start_column, truncated};
      if (pending_tokens.size() == 0) begin
        report({"unexpected token item: ", fmt_tok(got_tok)});
      end else begin
        want_tok = pending_tokens.pop_front();
        bad_fields = "";
        if (got_tok.ttype !== want_tok.ttype) bad_fields = {bad_fields, " token_kind"};
        if (got_tok.ch !== want_tok.ch) bad_fields = {bad_fields, " token_char"};
        if (got_tok.idx !== want_tok.idx) bad_fields = {bad_fields, " char_index"};
        if (got_tok.last !== want_tok.last) bad_fields = {bad_fields, " last_of_token"};
        if (got_tok.line !== want_tok.line) bad_fields = {bad_fields, " start_line"};
        if (got_tok.col !== want_tok.col) bad_fields = {bad_fields, " start_column"};
        if (got_tok.cut !== want_tok.cut) bad_fields = {bad_fields, " truncated"};
        if (bad_fields != "")
          report({"mismatch in", bad_fields, ": got ", fmt_tok(got_tok),
                  " / want ", fmt_tok(want_tok)});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (tok_valid && !tok_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    kw_word[0] = "define";
    kw_word[1] = "include";
    kw_word[2] = "setdir";
    kw_word[3] = "undef";
    dir_rows = '{
      '{"#", 1'b0, CHK_TYPED, '{TYPE_HASH, "#", 5'd0, 1'b1, 16'd1, 16'd1, 1'b0}},
      '{"@", 1'b0, CHK_TYPED, '{TYPE_UNKNOWN, "@", 5'd0, 1'b1, 16'd1, 16'd2, 1'b0}},
      '{8'hff, 1'b0, CHK_NONE, '0},
      '{CH_DEL, 1'b0, CHK_NONE, '0},
      '{8'h00, 1'b0, CHK_NONE, '0},
      // mixed-case keyword ended by a symbol: two tokens from one byte
      '{"U", 1'b0, CHK_MODEL, '0},
      '{"n", 1'b0, CHK_MODEL, '0},
      '{"D", 1'b0, CHK_MODEL, '0},
      '{"e", 1'b0, CHK_MODEL, '0},
      '{"F", 1'b0, CHK_MODEL, '0},
      '{"(", 1'b0, CHK_MODEL, '0},
      // del inside a string, then an empty string
      '{CH_QUOTE, 1'b0, CHK_MODEL, '0},
      '{CH_DEL, 1'b0, CHK_MODEL, '0},
      '{CH_QUOTE, 1'b0, CHK_MODEL, '0},
      '{CH_QUOTE, 1'b0, CHK_MODEL, '0},
      '{CH_QUOTE, 1'b0, CHK_MODEL, '0},
      // block comment closed after a run of stars
      '{CH_SLASH, 1'b0, CHK_MODEL, '0},
      '{CH_STAR, 1'b0, CHK_MODEL, '0},
      '{CH_STAR, 1'b0, CHK_MODEL, '0},
      '{CH_STAR, 1'b0, CHK_MODEL, '0},
      '{CH_SLASH, 1'b0, CHK_MODEL, '0},
      '{CH_SLASH, 1'b0, CHK_MODEL, '0},
      '{CH_SLASH, 1'b0, CHK_MODEL, '0},
      '{CH_NEWLINE, 1'b0, CHK_MODEL, '0},
      // lone slash, then a pending slash flushed at end of buffer
      '{CH_SLASH, 1'b0, CHK_MODEL, '0},
      '{"-", 1'b0, CHK_MODEL, '0},
      '{CH_SLASH, 1'b1, CHK_MODEL, '0}
    };
    lex_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 38;
          recv_idle <= 74;
        end
        1: begin
          send_idle = 74;
          recv_idle <= 38;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      if (phase == 0)
        for (int r = 0; r < 27; r++)
          drive_item(dir_rows[r].b, dir_rows[r].fin, dir_rows[r].chk, dir_rows[r].tok);
      while (rand_count < (phase + 1) * ITEMS_PER_PHASE) random_chunk();
      // end of buffer flushes whatever token is still open
      if (phase == 2) drive_item(" ", 1'b1, CHK_MODEL, '0);
    end
    byte_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stl_pkg.sv
rtl/stl_store.sv
rtl/script_token_lexer.sv
test/tb_script_token_lexer.sv
